// ===== sv/dwpid_pkg.sv =====
`default_nettype none
package dwpid_pkg;

   // item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_RIGHT_EDGE = 2'd0,
      KIND_LEFT_EDGE  = 2'd1,
      KIND_TICK       = 2'd2,
      KIND_UNUSED     = 2'd3
   } kind_type;

   // register indexes of the csr port
   typedef enum logic [1:0] {
      CSR_KP_GAIN      = 2'd0,
      CSR_KI_DT_GAIN   = 2'd1,
      CSR_KD_RATE_GAIN = 2'd2,
      CSR_COUNT_SCALE  = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_DATA_W-1:0] KP_RESET    = 16'd12800;
   localparam logic [CSR_DATA_W-1:0] KI_RESET    = 16'd256;
   localparam logic [CSR_DATA_W-1:0] KD_RESET    = 16'd2560;
   localparam logic [CSR_DATA_W-1:0] SCALE_RESET = 16'd10696;

   localparam int TARGET_W = 16;
   localparam int SPEED_W  = 24;
   localparam int ERR_W    = 25;
   localparam int DIFF_W   = 26;
   localparam int PWM_W    = 8;
   localparam int BRIDGE_W = 2;

   // shared multiplier: signed 17 x 33
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = 50;
   localparam int ACC_W   = 64;

   // clipped error sum and its split for the two partial products
   localparam int CLIP_W     = 48;
   localparam int CLIP_SHIFT = 46;
   localparam int SLICE_W    = 24;

   // speed is the rounded integer part of a Q.8 product, duty is the integer part of a Q.16 value
   localparam int SPEED_FRAC = 8;
   localparam int U_FRAC     = 16;

   localparam logic [SPEED_W-1:0]  SPEED_MAX = 24'hFFFFFF;
   localparam logic [PWM_W-1:0]    PWM_MAX   = 8'd255;
   localparam logic [BRIDGE_W-1:0] BRIDGE_P  = 2'b01;
   localparam logic [BRIDGE_W-1:0] BRIDGE_N  = 2'b10;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] kp;
      logic [CSR_DATA_W-1:0] ki;
      logic [CSR_DATA_W-1:0] kd;
      logic [CSR_DATA_W-1:0] scale;
   } cfg_type;

   typedef struct packed {
      logic [TARGET_W-1:0] right_target;
      logic [TARGET_W-1:0] left_target;
      logic                right_dir_p;
      logic                left_dir_p;
   } tick_type;

   localparam int TICK_W = $bits(tick_type);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_SPEED   = 10'b00_0000_0010,
      ST_ERROR   = 10'b00_0000_0100,
      ST_MUL_KP  = 10'b00_0000_1000,
      ST_MUL_KD  = 10'b00_0001_0000,
      ST_MUL_KIL = 10'b00_0010_0000,
      ST_MUL_KIH = 10'b00_0100_0000,
      ST_ACC_HI  = 10'b00_1000_0000,
      ST_DUTY    = 10'b01_0000_0000,
      ST_OUTPUT  = 10'b10_0000_0000
   } back_state_type;

endpackage
`default_nettype wire

// ===== sv/dual_wheel_pid_velocity_control.sv =====
// encoder edge transactions: one per cycle unless req_stall is high (queue full), no result
// tick transactions: the result loads into the output register once the output is free;
//   the back end runs eight steps per wheel through one shared 17x33 multiplier,
//   so it finishes one tick before it takes the next, with up to two ticks queued ahead
// reset: synchronous, active high; clears edge counts, error sums, previous errors,
//   queue and result valid flag, and loads the gain and scale reset values
`default_nettype none
module dual_wheel_pid_velocity_control import dwpid_pkg::*; #(
   parameter int COUNT_WIDTH = 16,
   parameter int SUM_WIDTH   = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_kind,
   input  wire logic [TARGET_W-1:0]    req_right_target,
   input  wire logic [TARGET_W-1:0]    req_left_target,
   input  wire logic                   req_right_dir_p,
   input  wire logic                   req_left_dir_p,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [PWM_W-1:0]       rsp_right_pwm,
   output logic      [PWM_W-1:0]       rsp_left_pwm,
   output logic      [BRIDGE_W-1:0]    rsp_right_bridge,
   output logic      [BRIDGE_W-1:0]    rsp_left_bridge,
   output logic      [SPEED_W-1:0]     rsp_right_speed,
   output logic      [SPEED_W-1:0]     rsp_left_speed,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int Q_W = 2 * COUNT_WIDTH + TICK_W;

   cfg_type cfg_ff, cfg_in;

   logic                   q_push, q_pop, q_full, q_empty;
   logic [COUNT_WIDTH-1:0] q_wr_cnt_right, q_wr_cnt_left;
   logic [COUNT_WIDTH-1:0] q_rd_cnt_right, q_rd_cnt_left;
   tick_type               q_wr_tick, q_rd_tick;
   logic [Q_W-1:0]         q_wdata, q_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KP_GAIN:      cfg_in.kp    = csr_wdata;
            CSR_KI_DT_GAIN:   cfg_in.ki    = csr_wdata;
            CSR_KD_RATE_GAIN: cfg_in.kd    = csr_wdata;
            CSR_COUNT_SCALE:  cfg_in.scale = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp    <= KP_RESET;
         cfg_ff.ki    <= KI_RESET;
         cfg_ff.kd    <= KD_RESET;
         cfg_ff.scale <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dwpid_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_right_target (req_right_target),
      .req_left_target  (req_left_target),
      .req_right_dir_p  (req_right_dir_p),
      .req_left_dir_p   (req_left_dir_p),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cnt_right      (q_wr_cnt_right),
      .q_cnt_left       (q_wr_cnt_left),
      .q_tick           (q_wr_tick)
   );

   assign q_wdata = {q_wr_cnt_right, q_wr_cnt_left, q_wr_tick};
   assign {q_rd_cnt_right, q_rd_cnt_left, q_rd_tick} = q_rdata;

   dwpid_fifo #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   dwpid_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .SUM_WIDTH   (SUM_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_cnt_right      (q_rd_cnt_right),
      .q_cnt_left       (q_rd_cnt_left),
      .q_tick           (q_rd_tick),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_right_pwm    (rsp_right_pwm),
      .rsp_left_pwm     (rsp_left_pwm),
      .rsp_right_bridge (rsp_right_bridge),
      .rsp_left_bridge  (rsp_left_bridge),
      .rsp_right_speed  (rsp_right_speed),
      .rsp_left_speed   (rsp_left_speed)
   );

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("tick pushed into a full queue");

   a_no_queue_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty))
      else $error("back end popped an empty queue");

   a_bridge_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_right_bridge == BRIDGE_P || rsp_right_bridge == BRIDGE_N)
                  && (rsp_left_bridge == BRIDGE_P || rsp_left_bridge == BRIDGE_N)))
      else $error("bridge output is not a legal direction code");

endmodule
`default_nettype wire

// ===== sv/dwpid_fifo.sv =====
`default_nettype none
module dwpid_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== sv/dwpid_front.sv =====
`default_nettype none
module dwpid_front import dwpid_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_kind,
   input  wire logic [TARGET_W-1:0]    req_right_target,
   input  wire logic [TARGET_W-1:0]    req_left_target,
   input  wire logic                   req_right_dir_p,
   input  wire logic                   req_left_dir_p,
   input  wire logic                   q_full,
   output logic                        q_push,
   output logic      [COUNT_WIDTH-1:0] q_cnt_right,
   output logic      [COUNT_WIDTH-1:0] q_cnt_left,
   output tick_type                    q_tick
);

   logic                   accept;
   kind_type               kind;
   logic [COUNT_WIDTH-1:0] cnt_right_ff, cnt_right_in;
   logic [COUNT_WIDTH-1:0] cnt_left_ff, cnt_left_in;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign kind      = kind_type'(req_kind);

   always_comb begin
      cnt_right_in = cnt_right_ff;
      cnt_left_in  = cnt_left_ff;
      q_push       = 1'b0;
      if (accept) begin
         unique case (kind)
            KIND_RIGHT_EDGE: begin
               if (cnt_right_ff != '1) begin
                  cnt_right_in = cnt_right_ff + COUNT_WIDTH'(1);
               end
            end
            KIND_LEFT_EDGE: begin
               if (cnt_left_ff != '1) begin
                  cnt_left_in = cnt_left_ff + COUNT_WIDTH'(1);
               end
            end
            KIND_TICK: begin
               // the counts of this interval travel with the tick
               q_push       = 1'b1;
               cnt_right_in = '0;
               cnt_left_in  = '0;
            end
            KIND_UNUSED: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign q_cnt_right         = cnt_right_ff;
   assign q_cnt_left          = cnt_left_ff;
   assign q_tick.right_target = req_right_target;
   assign q_tick.left_target  = req_left_target;
   assign q_tick.right_dir_p  = req_right_dir_p;
   assign q_tick.left_dir_p   = req_left_dir_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_right_ff <= '0;
         cnt_left_ff  <= '0;
      end else begin
         cnt_right_ff <= cnt_right_in;
         cnt_left_ff  <= cnt_left_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/dwpid_back.sv =====
`default_nettype none
module dwpid_back import dwpid_pkg::*; #(
   parameter int COUNT_WIDTH = 16,
   parameter int SUM_WIDTH   = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   input  wire logic [COUNT_WIDTH-1:0] q_cnt_right,
   input  wire logic [COUNT_WIDTH-1:0] q_cnt_left,
   input  wire tick_type               q_tick,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [PWM_W-1:0]       rsp_right_pwm,
   output logic      [PWM_W-1:0]       rsp_left_pwm,
   output logic      [BRIDGE_W-1:0]    rsp_right_bridge,
   output logic      [BRIDGE_W-1:0]    rsp_left_bridge,
   output logic      [SPEED_W-1:0]     rsp_right_speed,
   output logic      [SPEED_W-1:0]     rsp_left_speed
);

   localparam int XW = (SUM_WIDTH > CLIP_W) ? SUM_WIDTH : CLIP_W;

   back_state_type state_ff, state_in;
   logic           wheel_ff, wheel_in;

   // job in work
   logic [COUNT_WIDTH-1:0] cnt_right_ff, cnt_left_ff;
   tick_type               tick_ff;

   // datapath
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ERR_W-1:0]   err_ff, err_new;
   logic signed [DIFF_W-1:0]  diff_ff, diff_new;
   logic signed [CLIP_W-1:0]  clip_ff, clip_new;
   logic [SPEED_W-1:0]        spd_right_ff, spd_left_ff, speed_new;
   logic [PWM_W-1:0]          pwm_right_ff, pwm_left_ff, duty;

   // per-wheel loop state
   logic signed [SUM_WIDTH-1:0] sum_ff [2];
   logic signed [ERR_W-1:0]     prev_ff [2];
   logic signed [SUM_WIDTH-1:0] sum_new;

   logic [COUNT_WIDTH-1:0] cnt_sel;
   logic [TARGET_W-1:0]    target_sel;
   logic [PROD_W-1:0]      rounded;
   logic signed [SUM_WIDTH:0] sum_wide;
   logic signed [XW-1:0]   sum_x, clip_lim, clip_neg;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free, out_load;
   logic [PWM_W-1:0]    rsp_right_pwm_ff, rsp_left_pwm_ff;
   logic [BRIDGE_W-1:0] rsp_right_bridge_ff, rsp_left_bridge_ff;
   logic [SPEED_W-1:0]  rsp_right_speed_ff, rsp_left_speed_ff;

   assign cnt_sel    = wheel_ff ? cnt_left_ff : cnt_right_ff;
   assign target_sel = wheel_ff ? tick_ff.left_target : tick_ff.right_target;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SPEED: begin
            mul_a = $signed({1'b0, cfg.scale});
            mul_b = $signed({{(MUL_B_W - COUNT_WIDTH){1'b0}}, cnt_sel});
         end
         ST_MUL_KP: begin
            mul_a = $signed({1'b0, cfg.kp});
            mul_b = MUL_B_W'(err_ff);
         end
         ST_MUL_KD: begin
            mul_a = $signed({1'b0, cfg.kd});
            mul_b = MUL_B_W'(diff_ff);
         end
         ST_MUL_KIL: begin
            mul_a = $signed({1'b0, cfg.ki});
            mul_b = $signed({{(MUL_B_W - SLICE_W){1'b0}}, clip_ff[SLICE_W-1:0]});
         end
         ST_MUL_KIH: begin
            mul_a = $signed({1'b0, cfg.ki});
            mul_b = MUL_B_W'($signed(clip_ff[CLIP_W-1:SLICE_W]));
         end
         ST_IDLE, ST_ERROR, ST_ACC_HI, ST_DUTY, ST_OUTPUT: begin
         end
         default: begin
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // speed with rounding and saturation, error, saturating sum
   always_comb begin
      rounded   = prod_ff + PROD_W'(1 << (SPEED_FRAC - 1));
      speed_new = (|rounded[PROD_W-1:SPEED_W+SPEED_FRAC]) ? SPEED_MAX
                : rounded[SPEED_W+SPEED_FRAC-1:SPEED_FRAC];
      err_new   = ERR_W'(target_sel) - ERR_W'(speed_new);
      diff_new  = DIFF_W'(err_new) - DIFF_W'(prev_ff[wheel_ff]);
      sum_wide  = (SUM_WIDTH + 1)'(sum_ff[wheel_ff]) + (SUM_WIDTH + 1)'(err_new);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_new = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
      end else begin
         sum_new = sum_wide[SUM_WIDTH-1:0];
      end
   end

   // sum limited to +-2^46 before it meets the integral gain
   always_comb begin
      sum_x    = XW'(sum_ff[wheel_ff]);
      clip_lim = XW'(1) <<< CLIP_SHIFT;
      clip_neg = -clip_lim;
      if (sum_x > clip_lim) begin
         clip_new = clip_lim[CLIP_W-1:0];
      end else if (sum_x < clip_neg) begin
         clip_new = clip_neg[CLIP_W-1:0];
      end else begin
         clip_new = sum_x[CLIP_W-1:0];
      end
   end

   always_comb begin
      if (acc_ff[ACC_W-1] || acc_ff == '0) begin
         duty = '0;
      end else if (|acc_ff[ACC_W-2:PWM_W+U_FRAC]) begin
         duty = PWM_MAX;
      end else begin
         duty = acc_ff[PWM_W+U_FRAC-1:U_FRAC];
      end
   end

   // ST_MUL_KD loads, and ST_MUL_KIL to ST_ACC_HI add, the product started in the state before it
   always_comb begin
      acc_in = acc_ff;
      unique case (state_ff)
         ST_MUL_KD:  acc_in = ACC_W'(prod_ff);
         ST_MUL_KIL: acc_in = acc_ff + ACC_W'(prod_ff);
         ST_MUL_KIH: acc_in = acc_ff + ACC_W'(prod_ff);
         ST_ACC_HI:  acc_in = acc_ff + (ACC_W'(prod_ff) <<< SLICE_W);
         ST_IDLE, ST_SPEED, ST_ERROR, ST_MUL_KP, ST_DUTY, ST_OUTPUT: begin
         end
         default: begin
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      wheel_in = wheel_ff;
      q_pop    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               wheel_in = 1'b0;
               state_in = ST_SPEED;
            end
         end
         ST_SPEED:   state_in = ST_ERROR;
         ST_ERROR:   state_in = ST_MUL_KP;
         ST_MUL_KP:  state_in = ST_MUL_KD;
         ST_MUL_KD:  state_in = ST_MUL_KIL;
         ST_MUL_KIL: state_in = ST_MUL_KIH;
         ST_MUL_KIH: state_in = ST_ACC_HI;
         ST_ACC_HI:  state_in = ST_DUTY;
         ST_DUTY: begin
            if (!wheel_ff) begin
               wheel_in = 1'b1;
               state_in = ST_SPEED;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheel_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '{default: '0};
         prev_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_ERROR) begin
            sum_ff[wheel_ff]  <= sum_new;
            prev_ff[wheel_ff] <= err_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (q_pop) begin
         cnt_right_ff <= q_cnt_right;
         cnt_left_ff  <= q_cnt_left;
         tick_ff      <= q_tick;
      end
      if (state_ff == ST_ERROR) begin
         err_ff  <= err_new;
         diff_ff <= diff_new;
         if (wheel_ff) begin
            spd_left_ff <= speed_new;
         end else begin
            spd_right_ff <= speed_new;
         end
      end
      if (state_ff == ST_MUL_KP) begin
         clip_ff <= clip_new;
      end
      if (state_ff == ST_DUTY) begin
         if (wheel_ff) begin
            pwm_left_ff <= duty;
         end else begin
            pwm_right_ff <= duty;
         end
      end
      if (out_load) begin
         rsp_right_pwm_ff    <= pwm_right_ff;
         rsp_left_pwm_ff     <= pwm_left_ff;
         rsp_right_bridge_ff <= tick_ff.right_dir_p ? BRIDGE_P : BRIDGE_N;
         rsp_left_bridge_ff  <= tick_ff.left_dir_p ? BRIDGE_P : BRIDGE_N;
         rsp_right_speed_ff  <= spd_right_ff;
         rsp_left_speed_ff   <= spd_left_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_right_pwm    = rsp_right_pwm_ff;
   assign rsp_left_pwm     = rsp_left_pwm_ff;
   assign rsp_right_bridge = rsp_right_bridge_ff;
   assign rsp_left_bridge  = rsp_left_bridge_ff;
   assign rsp_right_speed  = rsp_right_speed_ff;
   assign rsp_left_speed   = rsp_left_speed_ff;

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb import dwpid_pkg::*; ();

   localparam int     COUNT_WIDTH    = 16;
   localparam int     SUM_WIDTH      = 40;
   localparam longint COUNT_TOP      = (64'sd1 <<< COUNT_WIDTH) - 64'sd1;
   localparam longint SUM_HI         = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
   localparam longint SUM_LO         = -SUM_HI - 64'sd1;
   localparam longint SUM_CLIP       = 64'sd1 <<< CLIP_SHIFT;
   localparam int     RIGHT          = 0;
   localparam int     LEFT           = 1;
   localparam int     PHASE_ITEMS    = 270;
   localparam int     SETTLE_CYCLES  = 30;
   localparam int     END_WAIT       = 20000;
   localparam int     CYCLE_LIMIT    = 2000000;

   typedef struct packed {
      logic [PWM_W-1:0]    right_pwm;
      logic [PWM_W-1:0]    left_pwm;
      logic [BRIDGE_W-1:0] right_bridge;
      logic [BRIDGE_W-1:0] left_bridge;
      logic [SPEED_W-1:0]  right_speed;
      logic [SPEED_W-1:0]  left_speed;
   } tick_result_type;

   class wheel_scoreboard;
      longint          gain_kp;
      longint          gain_ki;
      longint          gain_kd;
      longint          scale;
      longint          edge_count[2];
      longint          error_sum[2];
      longint          prev_error[2];
      tick_result_type expected_ticks[$];
      int              mismatches;
      int              results_seen;

      function new();
         gain_kp = KP_RESET;
         gain_ki = KI_RESET;
         gain_kd = KD_RESET;
         scale = SCALE_RESET;
         for (int w = 0; w < 2; w++) begin
            edge_count[w] = 0;
            error_sum[w] = 0;
            prev_error[w] = 0;
         end
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void set_gain(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_KP_GAIN:      gain_kp = val;
            CSR_KI_DT_GAIN:   gain_ki = val;
            CSR_KD_RATE_GAIN: gain_kd = val;
            CSR_COUNT_SCALE:  scale = val;
            default: ;
         endcase
      endfunction

      function longint wheel_speed(int w);
         longint v;
         v = (edge_count[w] * scale + 64'sd128) >>> SPEED_FRAC;
         if (v > longint'(SPEED_MAX))
            v = longint'(SPEED_MAX);
         return v;
      endfunction

      // one wheel of a tick: speed, error, saturating sum, then the clamped duty
      function void step_wheel(int w, logic [TARGET_W-1:0] target,
                               output logic [PWM_W-1:0] pwm, output logic [SPEED_W-1:0] speed);
         longint v;
         longint e;
         longint s;
         longint u;
         longint d;
         v = wheel_speed(w);
         edge_count[w] = 0;
         e = longint'(target) - v;
         if (e > 0 && error_sum[w] > SUM_HI - e)
            error_sum[w] = SUM_HI;
         else if (e < 0 && error_sum[w] < SUM_LO - e)
            error_sum[w] = SUM_LO;
         else
            error_sum[w] = error_sum[w] + e;
         s = error_sum[w];
         if (s > SUM_CLIP)
            s = SUM_CLIP;
         if (s < -SUM_CLIP)
            s = -SUM_CLIP;
         u = gain_kp * e + gain_ki * s + gain_kd * (e - prev_error[w]);
         prev_error[w] = e;
         if (u <= 0) begin
            pwm = '0;
         end else begin
            d = u >>> U_FRAC;
            pwm = (d > longint'(PWM_MAX)) ? PWM_MAX : d[PWM_W-1:0];
         end
         speed = v[SPEED_W-1:0];
      endfunction

      function void accept_item(kind_type k, logic [TARGET_W-1:0] rt, logic [TARGET_W-1:0] lt,
                                logic rd, logic ld);
         tick_result_type t;
         case (k)
            KIND_RIGHT_EDGE: if (edge_count[RIGHT] < COUNT_TOP) edge_count[RIGHT]++;
            KIND_LEFT_EDGE:  if (edge_count[LEFT] < COUNT_TOP) edge_count[LEFT]++;
            KIND_TICK: begin
               step_wheel(RIGHT, rt, t.right_pwm, t.right_speed);
               step_wheel(LEFT, lt, t.left_pwm, t.left_speed);
               t.right_bridge = rd ? BRIDGE_P : BRIDGE_N;
               t.left_bridge = ld ? BRIDGE_P : BRIDGE_N;
               expected_ticks.push_back(t);
            end
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_ticks.size();
      endfunction

      task flag_mismatch(string msg);
         $display("ERROR: result %0d: %s", results_seen, msg);
         mismatches++;
      endtask

      task compare_field(string name, longint got, longint want);
         if (got != want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_tick_result(tick_result_type got);
         tick_result_type want;
         results_seen++;
         if (expected_ticks.size() == 0) begin
            flag_mismatch("result with no tick transaction waiting");
            return;
         end
         want = expected_ticks.pop_front();
         compare_field("right_pwm", got.right_pwm, want.right_pwm);
         compare_field("left_pwm", got.left_pwm, want.left_pwm);
         compare_field("right_bridge", got.right_bridge, want.right_bridge);
         compare_field("left_bridge", got.left_bridge, want.left_bridge);
         compare_field("right_speed", got.right_speed, want.right_speed);
         compare_field("left_speed", got.left_speed, want.left_speed);
      endtask

      task flag_leftovers();
         while (expected_ticks.size() != 0) begin
            void'(expected_ticks.pop_front());
            flag_mismatch("expected tick result never arrived");
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_kind = KIND_RIGHT_EDGE;
   logic [TARGET_W-1:0]    req_right_target = '0;
   logic [TARGET_W-1:0]    req_left_target = '0;
   logic                   req_right_dir_p = 1'b0;
   logic                   req_left_dir_p = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PWM_W-1:0]       rsp_right_pwm;
   logic [PWM_W-1:0]       rsp_left_pwm;
   logic [BRIDGE_W-1:0]    rsp_right_bridge;
   logic [BRIDGE_W-1:0]    rsp_left_bridge;
   logic [SPEED_W-1:0]     rsp_right_speed;
   logic [SPEED_W-1:0]     rsp_left_speed;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_KP_GAIN;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   wheel_scoreboard sb;
   tick_result_type observed;
   bit              tx_idle = 1'b1;
   bit              rx_idle = 1'b1;
   int              stall_left = 0;
   int              cycle_count = 0;

   dual_wheel_pid_velocity_control #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .SUM_WIDTH(SUM_WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_right_target(req_right_target),
      .req_left_target(req_left_target),
      .req_right_dir_p(req_right_dir_p),
      .req_left_dir_p(req_left_dir_p),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_right_pwm(rsp_right_pwm),
      .rsp_left_pwm(rsp_left_pwm),
      .rsp_right_bridge(rsp_right_bridge),
      .rsp_left_bridge(rsp_left_bridge),
      .rsp_right_speed(rsp_right_speed),
      .rsp_left_speed(rsp_left_speed),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [TARGET_W-1:0] any16();
      return 16'($urandom());
   endfunction

   function automatic logic any_bit();
      return 1'($urandom());
   endfunction

   function automatic int edge_burst();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(0, 4);
      if (r < 98)
         return $urandom_range(5, 30);
      return $urandom_range(80, 200);
   endfunction

   // often near the measured speed so the loop sees small errors, else wide
   function automatic logic [TARGET_W-1:0] pick_target(int w);
      int     r;
      longint t;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         t = sb.wheel_speed(w) + longint'($urandom_range(0, 512)) - 64'sd256;
         if (t < 0)
            t = 0;
         if (t > 65535)
            t = 65535;
         return 16'(t);
      end
      if (r < 8)
         return 16'($urandom_range(0, 4095));
      return any16();
   endfunction

   // response side: check accepted results and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         observed.right_pwm = rsp_right_pwm;
         observed.left_pwm = rsp_left_pwm;
         observed.right_bridge = rsp_right_bridge;
         observed.left_bridge = rsp_left_bridge;
         observed.right_speed = rsp_right_speed;
         observed.left_speed = rsp_left_speed;
         sb.check_tick_result(observed);
      end
      if (stall_left == 0 && rx_idle)
         stall_left = idle_length();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic push_item(input kind_type k, input logic [TARGET_W-1:0] rt,
                            input logic [TARGET_W-1:0] lt, input logic rd, input logic ld);
      int gap;
      gap = tx_idle ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_right_target <= rt;
      req_left_target <= lt;
      req_right_dir_p <= rd;
      req_left_dir_p <= ld;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.accept_item(k, rt, lt, rd, ld);
   endtask

   // let every tick in flight come out before touching the registers
   task automatic settle_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_gain(idx, val);
   endtask

   task automatic load_gains(input logic [CSR_DATA_W-1:0] kp, input logic [CSR_DATA_W-1:0] ki,
                             input logic [CSR_DATA_W-1:0] kd, input logic [CSR_DATA_W-1:0] sc);
      csr_put(CSR_KP_GAIN, kp);
      csr_put(CSR_KI_DT_GAIN, ki);
      csr_put(CSR_KD_RATE_GAIN, kd);
      csr_put(CSR_COUNT_SCALE, sc);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_directed();
      // empty counts, zero target
      push_item(KIND_TICK, 16'd0, 16'd0, 1'b1, 1'b0);
      push_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      repeat (3) push_item(KIND_RIGHT_EDGE, 16'hFFFF, 16'd0, 1'b1, 1'b0);
      repeat (5) push_item(KIND_LEFT_EDGE, 16'd0, 16'hFFFF, 1'b0, 1'b1);
      // full targets drive the duty into its upper clamp
      push_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
      repeat (4) push_item(KIND_RIGHT_EDGE, 16'd0, 16'd0, 1'b0, 1'b0);
      repeat (4) push_item(KIND_LEFT_EDGE, 16'd0, 16'd0, 1'b0, 1'b0);
      // target under the measured speed, negative drive
      push_item(KIND_TICK, 16'd0, 16'd0, 1'b0, 1'b0);
      push_item(KIND_UNUSED, 16'd0, 16'd0, 1'b0, 1'b0);
      push_item(KIND_RIGHT_EDGE, 16'd0, 16'd0, 1'b1, 1'b1);
      // zero error on both wheels
      push_item(KIND_TICK, 16'(sb.wheel_speed(RIGHT)), 16'(sb.wheel_speed(LEFT)), 1'b1, 1'b1);
   endtask

   task automatic run_random(input int budget);
      int sent;
      int burst_r;
      int burst_l;
      sent = 0;
      while (sent < budget) begin
         burst_r = edge_burst();
         burst_l = edge_burst();
         while (burst_r + burst_l > 0) begin
            if ($urandom_range(0, 19) == 0)
               push_item(KIND_UNUSED, any16(), any16(), any_bit(), any_bit());
            if (burst_r > 0 && (burst_l == 0 || $urandom_range(0, 1) == 1)) begin
               push_item(KIND_RIGHT_EDGE, any16(), any16(), any_bit(), any_bit());
               burst_r--;
            end else begin
               push_item(KIND_LEFT_EDGE, any16(), any16(), any_bit(), any_bit());
               burst_l--;
            end
            sent++;
         end
         push_item(KIND_TICK, pick_target(RIGHT), pick_target(LEFT), any_bit(), any_bit());
         sent++;
         if ($urandom_range(0, 39) == 0)
            settle_block();
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle = 1'b1;
      rx_idle = 1'b1;
      run_directed();
      run_random(PHASE_ITEMS);

      settle_block();
      load_gains(16'($urandom_range(0, 8000)), 16'($urandom_range(0, 1024)),
                 16'($urandom_range(0, 4000)), 16'($urandom_range(2000, 30000)));
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      run_random(PHASE_ITEMS);

      settle_block();
      load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      run_random(PHASE_ITEMS);

      settle_block();
      load_gains(16'd0, 16'd0, 16'd0, 16'd0);
      tx_idle = 1'b1;
      rx_idle = 1'b0;
      run_random(PHASE_ITEMS / 2);

      settle_block();
      load_gains(any16(), any16(), any16(), any16());
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      run_random(PHASE_ITEMS);

      settle_block();
      load_gains(KP_RESET, KI_RESET, KD_RESET, SCALE_RESET);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      run_random(PHASE_ITEMS);

      req_valid <= 1'b0;
      for (int n = 0; n < END_WAIT && sb.pending() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.flag_leftovers();
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
sv/dwpid_pkg.sv
sv/dwpid_fifo.sv
sv/dwpid_front.sv
sv/dwpid_back.sv
sv/dual_wheel_pid_velocity_control.sv
test/tb.sv
